// ===== rtl/core/rmfh_pkg.sv =====
// Shared types and constants for the recursive mutex lock unit.
package rmfh_pkg;

   localparam int IdBitsDefault     = 8;
   localparam int QueueDepthDefault = 16;
   localparam int CountBitsDefault  = 16;

   typedef enum logic [1:0] {
      REQ_LOCK    = 2'd0,
      REQ_TRYLOCK = 2'd1,
      REQ_UNLOCK  = 2'd2,
      REQ_DESTROY = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BUSY   = 3'd1,
      ST_WAIT   = 3'd2,
      ST_INTR   = 3'd3,
      ST_NOTOWN = 3'd4,
      ST_FULL   = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] requester_id;
      logic       signal_pending;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        wake_valid;
      logic [7:0]  wake_thread;
      logic        owner_valid;
      logic [7:0]  owner_thread;
      logic [15:0] ref_count_now;
   } rsp_type;

endpackage

// ===== rtl/core/rmfh_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface rmfh_req_if;
   logic                  valid;
   logic                  ready;
   rmfh_pkg::req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rmfh_rsp_if;
   logic             valid;
   logic             ready;
   rmfh_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rmfh_queue_mem.sv =====
// Wait queue storage: one write port, one registered read port.
module rmfh_queue_mem #(
   parameter int ID_BITS     = rmfh_pkg::IdBitsDefault,
   parameter int QUEUE_DEPTH = rmfh_pkg::QueueDepthDefault,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ID_BITS-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [ID_BITS-1:0] rd_data
);
   logic [ID_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [ID_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/recursive_mutex_fifo_handoff.sv =====
// Top level of the recursive mutex lock unit with a first-in first-out wait queue.
// A request carries a kind (lock, trylock, unlock, destroy), a thread id and a
// signal flag; every accepted request yields exactly one response with status,
// wakeup hint, owner after the step and the reentry count.
// The wait queue lives in a single memory with a registered read port; entry 0
// is the front. One request is handled at a time. Unlock, destroy, owner
// relocks and trylocks that need no pop go from the decide state straight to
// the output state. A lock that must wait walks the queue one entry per cycle
// to find the requester (up to QUEUE_DEPTH reads), and a removal shifts the
// tail down one entry at a time, reading and then writing each entry; grant
// from the front pops by shifting, the same loop.
// Reset clears the owner, count and queue length; queue contents need no clear.
// The response sits in an output register; while the receiver stalls it holds,
// and no new request is taken until the response transfer completes.
module recursive_mutex_fifo_handoff #(
   parameter int ID_BITS     = rmfh_pkg::IdBitsDefault,
   parameter int QUEUE_DEPTH = rmfh_pkg::QueueDepthDefault,
   parameter int COUNT_BITS  = rmfh_pkg::CountBitsDefault
) (
   input logic        clock,
   input logic        reset,
   rmfh_req_if.sink   req,
   rmfh_rsp_if.source rsp
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECIDE = 7'b0000010,
      S_SEARCH = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_SHWR   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic                  sig_ff, sig_in;
   logic                  owned_ff, owned_in;
   logic [ID_BITS-1:0]    owner_ff, owner_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [LW-1:0]         pos_ff, pos_in;
   logic [2:0]            st_ff, st_in;
   logic                  wake_ff, wake_in;
   logic [ID_BITS-1:0]    wid_ff, wid_in;
   logic                  ovalid_ff, ovalid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ID_BITS-1:0] wr_data, rd_data;

   rmfh_queue_mem #(.ID_BITS(ID_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   logic is_owner;
   assign is_owner = owned_ff && (owner_ff == id_ff);

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; id_in = id_ff; sig_in = sig_ff;
      owned_in = owned_ff; owner_in = owner_ff; count_in = count_ff;
      len_in = len_ff; pos_in = pos_ff; st_in = st_ff;
      wake_in = wake_ff; wid_in = wid_ff; ovalid_in = ovalid_ff;
      wr_en = 1'b0; wr_addr = pos_ff[AW-1:0]; wr_data = id_ff;
      rd_addr = pos_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req.valid) begin
               kind_in = req.payload.req_type;
               id_in   = ID_BITS'(req.payload.requester_id);
               sig_in  = req.payload.signal_pending;
               pos_in  = '0;
               wake_in = 1'b0;
               wid_in  = '0;
               st_in   = rmfh_pkg::ST_OK;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // rd_data holds the queue front.
            state_in = S_OUT;
            unique case (kind_ff) inside
               rmfh_pkg::REQ_LOCK, rmfh_pkg::REQ_TRYLOCK: begin
                  if (is_owner) begin
                     if (count_ff == CMAX) st_in = rmfh_pkg::ST_FULL;
                     else count_in = count_ff + 1'b1;
                  end else if (!owned_ff &&
                               (len_ff == '0 || rd_data == id_ff)) begin
                     owned_in = 1'b1; owner_in = id_ff;
                     count_in = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                     if (len_ff != '0) begin
                        pos_in = '0; state_in = S_SHIFT;
                     end
                  end else if (kind_ff == rmfh_pkg::REQ_TRYLOCK) begin
                     st_in = rmfh_pkg::ST_BUSY;
                  end else begin
                     pos_in = '0;
                     if (len_ff == '0) state_in = S_CHECK;
                     else state_in = S_SEARCH;
                  end
               end
               rmfh_pkg::REQ_UNLOCK: begin
                  if (is_owner) begin
                     if (count_ff > 1) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        count_in = '0; owned_in = 1'b0; owner_in = '0;
                        if (len_ff != '0) begin
                           wake_in = 1'b1; wid_in = rd_data;
                        end
                     end
                  end else st_in = rmfh_pkg::ST_NOTOWN;
               end
               default: begin
                  if (len_ff == '0) begin
                     owned_in = 1'b0; owner_in = '0; count_in = '0;
                  end else st_in = rmfh_pkg::ST_BUSY;
               end
            endcase
         end
         S_SEARCH: begin
            // rd_data is entry pos_ff.
            if (rd_data == id_ff) begin
               state_in = S_CHECK;
            end else if (pos_ff + 1'b1 >= len_ff) begin
               pos_in = len_ff; state_in = S_CHECK;
            end else begin
               pos_in = pos_ff + 1'b1;
               rd_addr = pos_in[AW-1:0];
            end
         end
         S_CHECK: begin
            state_in = S_OUT;
            if (pos_ff == len_ff && len_ff >= LW'(QUEUE_DEPTH)) begin
               st_in = rmfh_pkg::ST_FULL;
            end else if (sig_ff) begin
               st_in = rmfh_pkg::ST_INTR;
               if (pos_ff != len_ff) state_in = S_SHIFT;
            end else begin
               st_in = rmfh_pkg::ST_WAIT;
               if (pos_ff == len_ff) begin
                  wr_en = 1'b1; len_in = len_ff + 1'b1;
               end
            end
         end
         S_SHIFT: begin
            // Remove entry pos_ff by moving the tail down one slot per pass.
            if (pos_ff + 1'b1 >= len_ff) begin
               len_in = len_ff - 1'b1; state_in = S_OUT;
            end else begin
               rd_addr = AW'(pos_ff + 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_data = rd_data;
            pos_in = pos_ff + 1'b1;
            state_in = S_SHIFT;
         end
         default: begin
            // S_OUT: response held until the transfer completes.
            ovalid_in = 1'b1;
            if (ovalid_ff && rsp.ready) begin
               ovalid_in = 1'b0; state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; owned_ff <= 1'b0; owner_ff <= '0;
         count_ff <= '0; len_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; owned_ff <= owned_in; owner_ff <= owner_in;
         count_ff <= count_in; len_ff <= len_in; ovalid_ff <= ovalid_in;
      end
      kind_ff <= kind_in; id_ff <= id_in; sig_ff <= sig_in; pos_ff <= pos_in;
      st_ff <= st_in; wake_ff <= wake_in; wid_ff <= wid_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovalid_ff;
   always_comb begin
      rsp.payload = '0;
      rsp.payload.status        = st_ff;
      rsp.payload.wake_valid    = wake_ff;
      rsp.payload.wake_thread   = 8'(wid_ff);
      rsp.payload.owner_valid   = owned_ff;
      rsp.payload.owner_thread  = owned_ff ? 8'(owner_ff) : 8'd0;
      rsp.payload.ref_count_now = 16'(count_ff);
   end
endmodule
